### rtl/core/khp_pkg.sv
// Shared types and constants for the header field parser.
`default_nettype none
package khp_pkg;

    // Command kinds carried from the front end to the back end.
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;
    localparam logic [1:0] KIND_NOP     = 2'd3;

    // Parse phases.
    localparam logic [2:0] PH_MAGIC   = 3'd0;
    localparam logic [2:0] PH_VERSION = 3'd1;
    localparam logic [2:0] PH_ID      = 3'd2;
    localparam logic [2:0] PH_SIZE    = 3'd3;
    localparam logic [2:0] PH_DATA    = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;
    localparam logic [2:0] PH_ERROR   = 3'd6;

    // Error codes.
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_TRUNCATED   = 4'd1;
    localparam logic [3:0] ERR_MAGIC       = 4'd2;
    localparam logic [3:0] ERR_VERSION     = 4'd3;
    localparam logic [3:0] ERR_CIPHER      = 4'd4;
    localparam logic [3:0] ERR_COMPRESSION = 4'd5;
    localparam logic [3:0] ERR_SEED        = 4'd6;
    localparam logic [3:0] ERR_ROUNDS      = 4'd7;
    localparam logic [3:0] ERR_IV          = 4'd8;
    localparam logic [3:0] ERR_STARTBYTES  = 4'd9;
    localparam logic [3:0] ERR_STREAMID    = 4'd10;
    localparam logic [3:0] ERR_BADID       = 4'd11;

    // Header field ids.
    localparam logic [7:0] FID_END         = 8'd0;
    localparam logic [7:0] FID_COMMENT     = 8'd1;
    localparam logic [7:0] FID_CIPHER      = 8'd2;
    localparam logic [7:0] FID_COMPRESSION = 8'd3;
    localparam logic [7:0] FID_MASTER_SEED = 8'd4;
    localparam logic [7:0] FID_XFORM_SEED  = 8'd5;
    localparam logic [7:0] FID_ROUNDS      = 8'd6;
    localparam logic [7:0] FID_IV          = 8'd7;
    localparam logic [7:0] FID_PROT_KEY    = 8'd8;
    localparam logic [7:0] FID_START_BYTES = 8'd9;
    localparam logic [7:0] FID_STREAM_ID   = 8'd10;

    localparam int MAGIC_LEN       = 8;
    localparam int VERSION_LEN     = 4;
    localparam int CIPHER_LEN      = 16;
    localparam int IV_LEN          = 16;
    localparam int START_BYTES_LEN = 32;

    localparam logic [7:0] MAGIC_BYTES [MAGIC_LEN] = '{
        8'h03, 8'hd9, 8'ha2, 8'h9a, 8'h67, 8'hfb, 8'h4b, 8'hb5
    };
    localparam logic [7:0] VERSION_BYTES [VERSION_LEN] = '{
        8'h01, 8'h00, 8'h03, 8'h00
    };
    localparam logic [7:0] CIPHER_BYTES [CIPHER_LEN] = '{
        8'h31, 8'hc1, 8'hf2, 8'he6, 8'hbf, 8'h71, 8'h43, 8'h50,
        8'hbe, 8'h58, 8'h05, 8'h21, 8'h6a, 8'hfc, 8'h5a, 8'hff
    };

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } khp_cmd_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [3:0]  error_code;
        logic [7:0]  field_id;
        logic [7:0]  data_byte;
        logic [15:0] data_offset;
        logic        field_last;
        logic        header_done;
        logic        gzip_flag;
        logic [63:0] transform_rounds;
        logic [31:0] inner_stream_id;
        logic [15:0] protected_key_length;
    } khp_result_t;

endpackage
`default_nettype wire

### rtl/core/kdbx_header_tlv_parser_core.sv
// An accepted beat is written into the queue, then parsed into the registered output.
// Throughput: one beat per cycle while the output is not stalled; the parse update is
// one combinational step in the back end. A two-entry queue separates accept and parse,
// so the input keeps flowing for two beats while the output stalls.
// Reset (rst_n low) empties the queue and output stage and returns the parser to the
// magic phase with all held header values cleared.
`default_nettype none
module kdbx_header_tlv_parser_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // [7:0] in_byte
    input  wire logic [1:0]    s_axis_tuser,   // [1:0] action
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // [3:0] error_code, [11:4] field_id, [19:12] data_byte, [35:20] data_offset,
    // [36] header_done, [37] gzip_flag, [101:38] transform_rounds,
    // [133:102] inner_stream_id, [149:134] protected_key_length, [151:150] zero
    output logic [151:0]       m_axis_tdata,
    output logic [2:0]         m_axis_tuser,   // [2:0] phase
    output logic               m_axis_tlast    // field_last
);
    import khp_pkg::*;

    logic        push;
    khp_cmd_t    push_cmd;
    logic        queue_full;
    logic        pop;
    logic        not_empty;
    khp_cmd_t    head_cmd;
    khp_result_t result;

    khp_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (push),
        .push_cmd      (push_cmd),
        .queue_full    (queue_full)
    );

    khp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_cmd  (head_cmd)
    );

    khp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (not_empty),
        .cmd       (head_cmd),
        .cmd_pop   (pop),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .result    (result)
    );

    assign m_axis_tdata = {
        2'b00,
        result.protected_key_length,
        result.inner_stream_id,
        result.transform_rounds,
        result.gzip_flag,
        result.header_done,
        result.data_offset,
        result.data_byte,
        result.field_id,
        result.error_code
    };
    assign m_axis_tuser = result.phase;
    assign m_axis_tlast = result.field_last;

endmodule
`default_nettype wire

### rtl/core/khp_front.sv
// Front end: accepts input beats and classifies them into parser commands.
`default_nettype none
module khp_front (
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [7:0]       s_axis_tdata,   // in_byte
    input  wire logic [1:0]       s_axis_tuser,   // action
    output logic                  push,
    output khp_pkg::khp_cmd_t     push_cmd,
    input  wire logic             queue_full
);
    import khp_pkg::*;

    always_comb
    begin
        push_cmd.data = s_axis_tdata;
        case (s_axis_tuser)
            KIND_BYTE:    push_cmd.kind = KIND_BYTE;
            KIND_END:     push_cmd.kind = KIND_END;
            KIND_RESTART: push_cmd.kind = KIND_RESTART;
            default:      push_cmd.kind = KIND_NOP;
        endcase
        // Only file bytes carry meaningful data.
        if (push_cmd.kind != KIND_BYTE)
        begin
            push_cmd.data = 8'd0;
        end
    end

    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

endmodule
`default_nettype wire

### rtl/core/khp_queue.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none
module khp_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire khp_pkg::khp_cmd_t  push_cmd,
    output logic                    full,
    input  wire logic               pop,
    output logic                    not_empty,
    output khp_pkg::khp_cmd_t       head_cmd
);
    import khp_pkg::*;

    khp_cmd_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_cmd  = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue count out of range");

    // The pointers differ exactly when one entry is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

### rtl/core/khp_back.sv
// Back end: header parse state machine and the registered result stage.
`default_nettype none
module khp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire khp_pkg::khp_cmd_t  cmd,
    output logic                    cmd_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output khp_pkg::khp_result_t    result
);
    import khp_pkg::*;

    logic [2:0]  phase_reg,  phase_next;
    logic [15:0] count_reg,  count_next;
    logic [7:0]  id_reg,     id_next;
    logic [15:0] size_reg,   size_next;
    logic        match_reg,  match_next;
    logic [63:0] asm_reg,    asm_next;
    logic [3:0]  err_reg,    err_next;
    logic        comp_reg,   comp_next;
    logic [63:0] rounds_reg, rounds_next;
    logic [31:0] sid_reg,    sid_next;
    logic [15:0] klen_reg,   klen_next;

    logic        out_valid_reg;
    khp_result_t out_reg;
    khp_result_t out_next;

    logic        fin;
    logic [15:0] offs;
    logic [7:0]  echo;
    logic [15:0] size_full;
    logic [15:0] count_inc;
    logic [31:0] low_word;

    assign cmd_pop = cmd_valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign result  = out_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        id_next     = id_reg;
        size_next   = size_reg;
        match_next  = match_reg;
        asm_next    = asm_reg;
        err_next    = err_reg;
        comp_next   = comp_reg;
        rounds_next = rounds_reg;
        sid_next    = sid_reg;
        klen_next   = klen_reg;
        fin         = 1'b0;
        offs        = 16'd0;
        echo        = 8'd0;
        size_full   = {cmd.data, size_reg[7:0]};
        count_inc   = count_reg + 16'd1;
        out_next    = out_reg;

        if (cmd_pop)
        begin
            case (cmd.kind)
                KIND_RESTART:
                begin
                    phase_next  = PH_MAGIC;
                    count_next  = 16'd0;
                    id_next     = 8'd0;
                    size_next   = 16'd0;
                    match_next  = 1'b1;
                    asm_next    = 64'd0;
                    err_next    = ERR_NONE;
                    comp_next   = 1'b0;
                    rounds_next = 64'd0;
                    sid_next    = 32'd0;
                    klen_next   = 16'd0;
                end
                KIND_END:
                begin
                    if (phase_reg inside {[PH_MAGIC:PH_DATA]})
                    begin
                        err_next   = ERR_TRUNCATED;
                        phase_next = PH_ERROR;
                    end
                end
                KIND_BYTE:
                begin
                    echo = cmd.data;
                    case (phase_reg)
                        PH_MAGIC:
                        begin
                            offs = count_reg;
                            if (cmd.data != MAGIC_BYTES[count_reg[2:0]])
                            begin
                                match_next = 1'b0;
                            end
                            count_next = count_inc;
                            if (count_inc >= 16'(MAGIC_LEN))
                            begin
                                if (match_next)
                                begin
                                    phase_next = PH_VERSION;
                                    count_next = 16'd0;
                                    match_next = 1'b1;
                                end
                                else
                                begin
                                    err_next   = ERR_MAGIC;
                                    phase_next = PH_ERROR;
                                end
                            end
                        end
                        PH_VERSION:
                        begin
                            offs = count_reg;
                            if (cmd.data != VERSION_BYTES[count_reg[1:0]])
                            begin
                                match_next = 1'b0;
                            end
                            count_next = count_inc;
                            if (count_inc >= 16'(VERSION_LEN))
                            begin
                                if (match_next)
                                begin
                                    phase_next = PH_ID;
                                    count_next = 16'd0;
                                    match_next = 1'b1;
                                end
                                else
                                begin
                                    err_next   = ERR_VERSION;
                                    phase_next = PH_ERROR;
                                end
                            end
                        end
                        PH_ID:
                        begin
                            id_next    = cmd.data;
                            count_next = 16'd0;
                            phase_next = PH_SIZE;
                        end
                        PH_SIZE:
                        begin
                            offs = count_reg;
                            if (count_reg == 16'd0)
                            begin
                                size_next  = {8'd0, cmd.data};
                                count_next = 16'd1;
                            end
                            else
                            begin
                                size_next  = size_full;
                                count_next = 16'd0;
                                match_next = 1'b1;
                                asm_next   = 64'd0;
                                if (size_full == 16'd0)
                                begin
                                    fin = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_DATA;
                                end
                            end
                        end
                        PH_DATA:
                        begin
                            offs = count_reg;
                            if (id_reg == FID_CIPHER && count_reg < 16'(CIPHER_LEN)
                                && cmd.data != CIPHER_BYTES[count_reg[3:0]])
                            begin
                                match_next = 1'b0;
                            end
                            // The first eight data bytes build a little-endian word.
                            if (count_reg[15:3] == 13'd0)
                            begin
                                asm_next[count_reg[2:0]*8 +: 8] = cmd.data;
                            end
                            if ({1'b0, count_reg} + 17'd1 == {1'b0, size_reg})
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                count_next = count_inc;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase

            low_word = asm_next[31:0];
            if (fin)
            begin
                count_next = 16'd0;
                phase_next = PH_ID;
                case (id_reg)
                    FID_END:
                    begin
                        phase_next = PH_DONE;
                    end
                    FID_COMMENT, FID_XFORM_SEED:
                    begin
                    end
                    FID_CIPHER:
                    begin
                        if (size_next != 16'(CIPHER_LEN) || !match_next)
                        begin
                            err_next   = ERR_CIPHER;
                            phase_next = PH_ERROR;
                        end
                    end
                    FID_COMPRESSION:
                    begin
                        if (size_next == 16'd4 && low_word[31:1] == 31'd0)
                        begin
                            comp_next = low_word[0];
                        end
                        else
                        begin
                            err_next   = ERR_COMPRESSION;
                            phase_next = PH_ERROR;
                        end
                    end
                    FID_MASTER_SEED:
                    begin
                        if (size_next != 16'd32)
                        begin
                            err_next   = ERR_SEED;
                            phase_next = PH_ERROR;
                        end
                    end
                    FID_ROUNDS:
                    begin
                        if (size_next == 16'd8)
                        begin
                            rounds_next = asm_next;
                        end
                        else
                        begin
                            err_next   = ERR_ROUNDS;
                            phase_next = PH_ERROR;
                        end
                    end
                    FID_IV:
                    begin
                        if (size_next != 16'(IV_LEN))
                        begin
                            err_next   = ERR_IV;
                            phase_next = PH_ERROR;
                        end
                    end
                    FID_PROT_KEY:
                    begin
                        klen_next = size_next;
                    end
                    FID_START_BYTES:
                    begin
                        if (size_next != 16'(START_BYTES_LEN))
                        begin
                            err_next   = ERR_STARTBYTES;
                            phase_next = PH_ERROR;
                        end
                    end
                    FID_STREAM_ID:
                    begin
                        if (size_next == 16'd4)
                        begin
                            sid_next = low_word;
                        end
                        else
                        begin
                            err_next   = ERR_STREAMID;
                            phase_next = PH_ERROR;
                        end
                    end
                    default:
                    begin
                        err_next   = ERR_BADID;
                        phase_next = PH_ERROR;
                    end
                endcase
            end

            out_next.phase                = phase_next;
            out_next.error_code           = err_next;
            out_next.field_id             = id_next;
            out_next.data_byte            = echo;
            out_next.data_offset          = offs;
            out_next.field_last           = fin;
            out_next.header_done          = (phase_next == PH_DONE);
            out_next.gzip_flag            = comp_next;
            out_next.transform_rounds     = rounds_next;
            out_next.inner_stream_id      = sid_next;
            out_next.protected_key_length = klen_next;
        end
        else
        begin
            low_word = asm_reg[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAGIC;
            count_reg     <= 16'd0;
            id_reg        <= 8'd0;
            size_reg      <= 16'd0;
            match_reg     <= 1'b1;
            asm_reg       <= 64'd0;
            err_reg       <= ERR_NONE;
            comp_reg      <= 1'b0;
            rounds_reg    <= 64'd0;
            sid_reg       <= 32'd0;
            klen_reg      <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            id_reg     <= id_next;
            size_reg   <= size_next;
            match_reg  <= match_next;
            asm_reg    <= asm_next;
            err_reg    <= err_next;
            comp_reg   <= comp_next;
            rounds_reg <= rounds_next;
            sid_reg    <= sid_next;
            klen_reg   <= klen_next;
            if (cmd_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // An error code is held exactly while the parser sits in the error phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_NONE) == (phase_reg == PH_ERROR))
        else $error("sticky error and error phase disagree");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MAGIC) |-> (count_reg < 16'(MAGIC_LEN)))
        else $error("magic byte counter overran");

    // State only moves when a command is taken from the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_pop |=> $stable(phase_reg) && $stable(err_reg))
        else $error("parser state changed without a command");

endmodule
`default_nettype wire

### test/tlv_header_checker.sv
// Watches both streams of the header parser, predicts every result beat and compares it.
`timescale 1ns / 100ps
module tlv_header_checker
    import khp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,
    input  wire logic [1:0]   s_axis_tuser,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [151:0] m_axis_tdata,
    input  wire logic [2:0]   m_axis_tuser,
    input  wire logic         m_axis_tlast,
    output int                mismatches,
    output int                outstanding
);

    // Predicted parser state.
    logic [2:0]  ph;
    logic [15:0] cnt;
    logic [7:0]  cur_id;
    logic [15:0] cur_size;
    logic        match_ok;
    logic [63:0] acc;
    logic [3:0]  err;
    logic        gzip;
    logic [63:0] rounds;
    logic [31:0] stream_id;
    logic [15:0] key_len;

    khp_result_t expected_results[$];
    int          results_seen;

    task report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $realtime, msg);
        mismatches = mismatches + 1;
    endtask

    task compare_field(input string name, input logic [63:0] got, input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                results_seen, name, got, want));
    endtask

    task clear_parser();
        ph        = PH_MAGIC;
        cnt       = '0;
        cur_id    = '0;
        cur_size  = '0;
        match_ok  = 1'b1;
        acc       = '0;
        err       = ERR_NONE;
        gzip      = 1'b0;
        rounds    = '0;
        stream_id = '0;
        key_len   = '0;
    endtask

    task raise_error(input logic [3:0] code);
        err = code;
        ph  = PH_ERROR;
    endtask

    // Applies the per-id checks once the whole field has been read.
    task close_field();
        cnt = '0;
        ph  = PH_ID;
        case (cur_id)
            FID_END:
                ph = PH_DONE;
            FID_COMMENT, FID_XFORM_SEED:
                ;
            FID_CIPHER:
                if (cur_size != CIPHER_LEN || !match_ok)
                    raise_error(ERR_CIPHER);
            FID_COMPRESSION:
                if (cur_size == 4 && acc[31:0] <= 32'd1)
                    gzip = acc[0];
                else
                    raise_error(ERR_COMPRESSION);
            FID_MASTER_SEED:
                if (cur_size != 32)
                    raise_error(ERR_SEED);
            FID_ROUNDS:
                if (cur_size == 8)
                    rounds = acc;
                else
                    raise_error(ERR_ROUNDS);
            FID_IV:
                if (cur_size != IV_LEN)
                    raise_error(ERR_IV);
            FID_PROT_KEY:
                key_len = cur_size;
            FID_START_BYTES:
                if (cur_size != START_BYTES_LEN)
                    raise_error(ERR_STARTBYTES);
            FID_STREAM_ID:
                if (cur_size == 4)
                    stream_id = acc[31:0];
                else
                    raise_error(ERR_STREAMID);
            default:
                raise_error(ERR_BADID);
        endcase
    endtask

    task parse_header_beat(input khp_cmd_t cmd, output khp_result_t r);
        logic [15:0] offs;
        logic        last;
        logic [7:0]  echo;
        logic        hit;
        int          len;
        offs = '0;
        last = 1'b0;
        echo = '0;
        case (cmd.kind)
            KIND_RESTART:
                clear_parser();
            KIND_END:
                if (ph < PH_DONE)
                    raise_error(ERR_TRUNCATED);
            KIND_BYTE:
            begin
                echo = cmd.data;
                case (ph)
                    PH_MAGIC, PH_VERSION:
                    begin
                        offs = cnt;
                        if (ph == PH_MAGIC)
                        begin
                            len = MAGIC_LEN;
                            hit = (cnt < MAGIC_LEN) && (cmd.data == MAGIC_BYTES[cnt]);
                        end
                        else
                        begin
                            len = VERSION_LEN;
                            hit = (cnt < VERSION_LEN) && (cmd.data == VERSION_BYTES[cnt]);
                        end
                        if (!hit)
                            match_ok = 1'b0;
                        cnt = cnt + 16'd1;
                        // The comparison verdict is only given after the last byte.
                        if (cnt >= len)
                        begin
                            if (match_ok)
                            begin
                                ph       = ph + 3'd1;
                                cnt      = '0;
                                match_ok = 1'b1;
                            end
                            else
                                raise_error(ph == PH_MAGIC ? ERR_MAGIC : ERR_VERSION);
                        end
                    end
                    PH_ID:
                    begin
                        cur_id = cmd.data;
                        cnt    = '0;
                        ph     = PH_SIZE;
                    end
                    PH_SIZE:
                    begin
                        offs = cnt;
                        if (cnt == 0)
                        begin
                            cur_size = {8'h00, cmd.data};
                            cnt      = 16'd1;
                        end
                        else
                        begin
                            cur_size = {cmd.data, cur_size[7:0]};
                            cnt      = '0;
                            match_ok = 1'b1;
                            acc      = '0;
                            // An empty field completes on its second size byte.
                            if (cur_size == 0)
                            begin
                                last = 1'b1;
                                close_field();
                            end
                            else
                                ph = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        offs = cnt;
                        if (cur_id == FID_CIPHER && cnt < CIPHER_LEN
                            && cmd.data != CIPHER_BYTES[cnt])
                            match_ok = 1'b0;
                        if (cnt < 8)
                            acc = acc | (64'(cmd.data) << (8 * cnt));
                        if ({1'b0, cnt} + 17'd1 == {1'b0, cur_size})
                        begin
                            last = 1'b1;
                            close_field();
                        end
                        else
                            cnt = cnt + 16'd1;
                    end
                    default:
                        ;
                endcase
            end
            default:
                ;
        endcase
        r.phase                = ph;
        r.error_code           = err;
        r.field_id             = cur_id;
        r.data_byte            = echo;
        r.data_offset          = offs;
        r.field_last           = last;
        r.header_done          = (ph == PH_DONE);
        r.gzip_flag            = gzip;
        r.transform_rounds     = rounds;
        r.inner_stream_id      = stream_id;
        r.protected_key_length = key_len;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        khp_result_t want;
        khp_result_t pred;
        if (!rst_n)
        begin
            clear_parser();
            expected_results.delete();
            results_seen = 0;
            mismatches   = 0;
            outstanding <= 0;
        end
        else
        begin
            // Check before predicting: a beat accepted now cannot leave in the same cycle.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing predicted",
                        results_seen));
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("phase", m_axis_tuser, want.phase);
                    compare_field("error_code", m_axis_tdata[3:0], want.error_code);
                    compare_field("field_id", m_axis_tdata[11:4], want.field_id);
                    compare_field("data_byte", m_axis_tdata[19:12], want.data_byte);
                    compare_field("data_offset", m_axis_tdata[35:20], want.data_offset);
                    compare_field("field_last", m_axis_tlast, want.field_last);
                    compare_field("header_done", m_axis_tdata[36], want.header_done);
                    compare_field("gzip_flag", m_axis_tdata[37], want.gzip_flag);
                    compare_field("transform_rounds", m_axis_tdata[101:38],
                        want.transform_rounds);
                    compare_field("inner_stream_id", m_axis_tdata[133:102],
                        want.inner_stream_id);
                    compare_field("protected_key_length", m_axis_tdata[149:134],
                        want.protected_key_length);
                    compare_field("pad", m_axis_tdata[151:150], 64'd0);
                end
                results_seen = results_seen + 1;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_header_beat('{kind: s_axis_tuser, data: s_axis_tdata}, pred);
                expected_results.push_back(pred);
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

### test/tb_top.sv
// Top of the header parser testbench: clock, reset, byte stimulus, output back-pressure, verdict.
`timescale 1ns / 100ps
module tb_top;
    import khp_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;
    int           mismatches;
    int           outstanding;

    bit           sender_idles;
    bit           hold_req;
    int           beats_sent;
    khp_cmd_t     beat_q[$];

    kdbx_header_tlv_parser_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    tlv_header_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("FAIL kdbx_header_tlv_parser_core");
        $finish;
    end

    // Offers every queued beat in order, with optional gaps before each one.
    task send_queue();
        khp_cmd_t cmd;
        int       gap;
        int       r;
        while (beat_q.size() > 0)
        begin
            cmd = beat_q.pop_front();
            gap = 0;
            if (sender_idles)
            begin
                r = $urandom_range(0, 99);
                if (r >= 95)
                    gap = $urandom_range(8, 30);
                else if (r >= 65)
                    gap = $urandom_range(1, 3);
            end
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= cmd.data;
            s_axis_tuser  <= cmd.kind;
            do
                @(posedge clk);
            while (!s_axis_tready);
            beats_sent = beats_sent + 1;
        end
        // The last beat has been taken; stop offering it.
        s_axis_tvalid <= 1'b0;
    endtask

    // The count from the checker is registered, so let it update past the last accept before reading it.
    task drain_results();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Queues a restart followed by one header, mostly well formed with random content.
    task queue_header();
        logic [7:0] hdr[$];
        logic [7:0] v;
        int         id;
        int         size;
        int         n_fields;
        int         k;
        int         cut;
        int         spot;
        bit         tidy;
        bit         spoiled;
        bit         open_ended;
        hdr        = {};
        spoiled    = 1'b0;
        open_ended = 1'b0;
        for (k = 0; k < MAGIC_LEN; k++)
            hdr.push_back(MAGIC_BYTES[k]);
        for (k = 0; k < VERSION_LEN; k++)
            hdr.push_back(VERSION_BYTES[k]);
        n_fields = $urandom_range(1, 8);
        if ($urandom_range(0, 99) < 8)
        begin
            spot = $urandom_range(0, MAGIC_LEN + VERSION_LEN - 1);
            hdr[spot] = hdr[spot] ^ 8'($urandom_range(1, 255));
            spoiled  = 1'b1;
            n_fields = 0;
        end
        for (int f = 0; f < n_fields && !open_ended; f++)
        begin
            id = ($urandom_range(0, 99) < 6) ? $urandom_range(11, 255) : $urandom_range(1, 10);
            case (id)
                FID_CIPHER:                       size = CIPHER_LEN;
                FID_IV:                           size = IV_LEN;
                FID_COMPRESSION, FID_STREAM_ID:   size = 4;
                FID_MASTER_SEED, FID_START_BYTES: size = START_BYTES_LEN;
                FID_ROUNDS:                       size = 8;
                default:                          size = $urandom_range(0, 6);
            endcase
            if ($urandom_range(0, 99) < 12)
                size = $urandom_range(0, 40);
            // A huge size is only started; the stream is ended inside its data.
            if ($urandom_range(0, 99) < 3)
            begin
                size       = $urandom_range(256, 65535);
                open_ended = 1'b1;
            end
            tidy = ($urandom_range(0, 99) < 80);
            spot = $urandom_range(0, CIPHER_LEN - 1);
            hdr.push_back(8'(id));
            hdr.push_back(8'(size));
            hdr.push_back(8'(size >> 8));
            for (k = 0; k < (open_ended ? 6 : size); k++)
            begin
                v = 8'($urandom_range(0, 255));
                if (id == FID_CIPHER && k < CIPHER_LEN && (tidy || k != spot))
                    v = CIPHER_BYTES[k];
                if (id == FID_COMPRESSION && tidy)
                    v = (k == 0) ? 8'($urandom_range(0, 1)) : 8'h00;
                hdr.push_back(v);
            end
        end
        if (!spoiled && !open_ended && $urandom_range(0, 99) < 85)
        begin
            size = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            hdr.push_back(FID_END);
            hdr.push_back(8'(size));
            hdr.push_back(8'h00);
            repeat (size) hdr.push_back(8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 3)) hdr.push_back(8'($urandom_range(0, 255)));

        beat_q.push_back('{KIND_RESTART, 8'($urandom_range(0, 255))});
        cut = ($urandom_range(0, 99) < 10) ? $urandom_range(0, hdr.size() - 1) : -1;
        for (k = 0; k < hdr.size(); k++)
        begin
            if (k == cut)
                break;
            if ($urandom_range(0, 99) < 2)
                beat_q.push_back('{KIND_NOP, 8'($urandom_range(0, 255))});
            beat_q.push_back('{KIND_BYTE, hdr[k]});
        end
        if (cut >= 0 || open_ended || $urandom_range(0, 1) == 1)
            beat_q.push_back('{KIND_END, 8'($urandom_range(0, 255))});
    endtask

    // Output side: random stalls, quiet stretches, and one long hold-off on request.
    initial
    begin
        int stall_left;
        int cyc;
        bit rx_idles;
        bit hold_done;
        stall_left    = 0;
        cyc           = 0;
        rx_idles      = 1'b1;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc = cyc + 1;
            if (cyc % 150 == 0)
                rx_idles = ($urandom_range(0, 3) != 0);
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (80) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else if (rx_idles && $urandom_range(0, 99) < 25)
            begin
                m_axis_tready <= 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                         : $urandom_range(0, 2);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int k;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = KIND_NOP;
        hold_req      = 1'b0;
        sender_idles  = 1'b0;
        beats_sent    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme bytes, a no-op, a stream end mid-magic and a byte after the error.
        beat_q.push_back('{KIND_BYTE, 8'h00});
        beat_q.push_back('{KIND_BYTE, 8'hff});
        beat_q.push_back('{KIND_NOP, 8'h00});
        beat_q.push_back('{KIND_END, 8'hff});
        beat_q.push_back('{KIND_BYTE, 8'hab});
        beat_q.push_back('{KIND_RESTART, 8'h00});
        // Shortest valid header: magic, version and an empty end field.
        for (k = 0; k < MAGIC_LEN; k++)
            beat_q.push_back('{KIND_BYTE, MAGIC_BYTES[k]});
        for (k = 0; k < VERSION_LEN; k++)
            beat_q.push_back('{KIND_BYTE, VERSION_BYTES[k]});
        beat_q.push_back('{KIND_BYTE, FID_END});
        beat_q.push_back('{KIND_BYTE, 8'h00});
        beat_q.push_back('{KIND_BYTE, 8'h00});
        // Bytes and a stream end after the header change nothing.
        beat_q.push_back('{KIND_BYTE, 8'h55});
        beat_q.push_back('{KIND_END, 8'h00});
        beat_q.push_back('{KIND_RESTART, 8'hff});
        send_queue();
        drain_results();

        // The first random header goes out back to back while the output is held off.
        hold_req <= 1'b1;
        while (beats_sent < 770)
        begin
            queue_header();
            send_queue();
            sender_idles = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0)
                drain_results();
        end
        s_axis_tvalid <= 1'b0;
        drain_results();
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("PASS kdbx_header_tlv_parser_core");
        else
            $display("FAIL kdbx_header_tlv_parser_core");
        $finish;
    end

endmodule
